/* src/rolling_hash_string_matcher_top_defines.svh */
// Assertion macros for the rolling hash matcher checker.
`ifndef ROLLING_HASH_STRING_MATCHER_TOP_DEFINES_SVH
`define ROLLING_HASH_STRING_MATCHER_TOP_DEFINES_SVH

// Implication checked every clock, masked while in reset.
`define RHSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhsm check failed");

// Consequent checked in the cycle after the antecedent.
`define RHSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhsm check failed");

`endif

/* src/rhsm_pkg.sv */
`timescale 1ns / 1ps

package rhsm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int PIDX_W      = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 21;
    localparam int HASH_W      = 30;

    localparam logic [CNT_W-1:0]  MAX_TEXT   = 21'd1048576;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 7'd64;
    localparam logic [HASH_W-1:0] MOD_M      = 30'd1000000007;
    localparam logic [31:0]       MOD_M2     = 32'd2000000014;
    localparam logic [31:0]       MOD_M3     = 32'd3000000021;
    // 2^30 mod M, used to fold the high bits of a product
    localparam logic [26:0]       FOLD_C     = 27'd73741817;
    localparam logic [7:0]        SYM_BIAS   = 8'd96;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_TOP_INIT,
        S_TOP_LOOP,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_ADD,
        S_CHECK,
        S_VISSUE,
        S_VLOOP,
        S_DONE,
        S_DONE_HIT
    } state_t;

    typedef struct packed {
        logic latch;
        logic prep;
        logic top_init;
        logic top_step;
        logic add;
        logic vclr;
        logic vinc;
        logic verify;
        logic out_load;
        logic res_match;
    } cmd_t;

    typedef struct packed {
        logic is_text;
        logic need_top;
        logic step_zero;
        logic step_end;
        logic hit;
        logic mismatch;
        logic out_free;
    } sts_t;

    function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MOD_M})
        begin
            s = s - {1'b0, MOD_M};
        end
        return s[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] mod_dbl(input logic [HASH_W-1:0] a);
        return mod_add(a, a);
    endfunction

    // times the inverse of 2
    function automatic logic [HASH_W-1:0] mod_half(input logic [HASH_W-1:0] a);
        logic [HASH_W:0] s;
        s = {1'b0, a};
        if (a[0])
        begin
            s = s + {1'b0, MOD_M};
        end
        return s[HASH_W:1];
    endfunction

endpackage

/* src/rhsm_ram.sv */
`timescale 1ns / 1ps

module rhsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/rhsm_ctrl.sv */
`timescale 1ns / 1ps

module rhsm_ctrl import rhsm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = sts.need_top ? S_TOP_INIT : S_MUL1;
            end
            S_TOP_INIT:
            begin
                cmd.top_init = 1'b1;
                state_next   = S_TOP_LOOP;
            end
            S_TOP_LOOP:
            begin
                if (sts.step_zero)
                begin
                    state_next = S_MUL1;
                end
                else
                begin
                    cmd.top_step = 1'b1;
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_MUL3;
            S_MUL3: state_next = S_MUL4;
            S_MUL4: state_next = S_ADD;
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.is_text && sts.hit)
                begin
                    cmd.vclr   = 1'b1;
                    state_next = S_VISSUE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_VISSUE:
            begin
                cmd.verify = 1'b1;
                cmd.vinc   = 1'b1;
                state_next = S_VLOOP;
            end
            S_VLOOP:
            begin
                cmd.verify = 1'b1;
                priority if (sts.mismatch)
                begin
                    state_next = S_DONE;
                end
                else if (sts.step_end)
                begin
                    state_next = S_DONE_HIT;
                end
                else
                begin
                    cmd.vinc = 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DONE_HIT:
            begin
                cmd.res_match = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* src/rhsm_datapath.sv */
`timescale 1ns / 1ps

module rhsm_datapath import rhsm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              action,
    input  logic [7:0]        symbol,
    input  logic [PIDX_W-1:0] pattern_index,
    input  logic              text_start,
    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              match,
    output logic [CNT_W-1:0]  start_position,
    output logic              window_full
);

    logic              action_reg;
    logic [7:0]        sym_reg;
    logic [PIDX_W-1:0] pidx_reg;
    logic              tstart_reg;

    logic [LEN_W-1:0]  cfg_len_reg;
    logic [HASH_W-1:0] ph_reg;
    logic [HASH_W-1:0] lw_reg;
    logic [HASH_W-1:0] wh_reg;
    logic [HASH_W-1:0] tw_reg;
    logic [HASH_W-1:0] top_reg;
    logic [LEN_W-1:0]  top_len_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PIDX_W-1:0] rp_reg;
    logic [LEN_W-1:0]  step_reg;
    logic              out_valid_reg;
    logic              match_reg;
    logic [CNT_W-1:0]  start_reg;
    logic              full_reg;

    logic [37:0]       p1_reg;
    logic [34:0]       f1_reg;
    logic [31:0]       f2_reg;
    logic [HASH_W-1:0] term_reg;
    logic [HASH_W-1:0] hsub_reg;
    logic [HASH_W-1:0] half_reg;

    logic [LEN_W-1:0]  len;
    logic              fill;
    logic [HASH_W-1:0] weight;
    logic [7:0]        mag;
    logic              neg;
    logic [31:0]       red32;
    logic [HASH_W-1:0] red;
    logic [HASH_W-1:0] hsub_next;
    logic [HASH_W-1:0] sub_d;
    logic [7:0]        ring_q;
    logic [7:0]        store_q;
    logic [PIDX_W-1:0] ring_raddr;

    always_comb
    begin
        priority if (cfg_len_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg_len_reg > LEN_MAX)
        begin
            len = LEN_MAX;
        end
        else
        begin
            len = cfg_len_reg;
        end
    end

    assign fill = count_reg < CNT_W'(len);

    always_comb
    begin
        if (!action_reg)
        begin
            weight = (pidx_reg == '0) ? HASH_W'(1) : lw_reg;
        end
        else
        begin
            weight = fill ? tw_reg : top_reg;
        end
    end

    assign neg = sym_reg < SYM_BIAS;
    assign mag = neg ? (SYM_BIAS - sym_reg) : (sym_reg - SYM_BIAS);

    always_comb
    begin
        priority if (f2_reg >= MOD_M3)
        begin
            red32 = f2_reg - MOD_M3;
        end
        else if (f2_reg >= MOD_M2)
        begin
            red32 = f2_reg - MOD_M2;
        end
        else if (f2_reg >= 32'(MOD_M))
        begin
            red32 = f2_reg - 32'(MOD_M);
        end
        else
        begin
            red32 = f2_reg;
        end
    end
    assign red = red32[HASH_W-1:0];

    // window hash minus the value of the leaving byte
    always_comb
    begin
        sub_d = '0;
        if (ring_q < SYM_BIAS)
        begin
            hsub_next = mod_add(wh_reg, HASH_W'(SYM_BIAS - ring_q));
        end
        else
        begin
            sub_d = HASH_W'(ring_q - SYM_BIAS);
            if (wh_reg >= sub_d)
            begin
                hsub_next = wh_reg - sub_d;
            end
            else
            begin
                hsub_next = wh_reg + (MOD_M - sub_d);
            end
        end
    end

    // modular multiply pipeline, free running on stable operands
    always_ff @(posedge clk)
    begin
        p1_reg   <= 38'(mag) * 38'(weight);
        f1_reg   <= 35'(p1_reg[37:30]) * 35'(FOLD_C) + 35'(p1_reg[29:0]);
        f2_reg   <= 32'(f1_reg[34:30]) * 32'(FOLD_C) + 32'(f1_reg[29:0]);
        term_reg <= (neg && red != '0) ? (MOD_M - red) : red;
        hsub_reg <= hsub_next;
        half_reg <= mod_half(hsub_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            sym_reg    <= symbol;
            pidx_reg   <= pattern_index;
            tstart_reg <= text_start;
        end
        if (cmd.out_load)
        begin
            match_reg <= cmd.res_match;
            start_reg <= cmd.res_match ? (count_reg - CNT_W'(len) + CNT_W'(1)) : '0;
            full_reg  <= !fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg   <= LEN_W'(1);
            ph_reg        <= '0;
            lw_reg        <= HASH_W'(1);
            wh_reg        <= '0;
            tw_reg        <= HASH_W'(1);
            top_reg       <= HASH_W'(1);
            top_len_reg   <= LEN_W'(1);
            count_reg     <= '0;
            rp_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_len_reg <= cfg_wr_data;
            end
            if (cmd.prep && action_reg && tstart_reg)
            begin
                wh_reg    <= '0;
                count_reg <= '0;
                rp_reg    <= '0;
                tw_reg    <= HASH_W'(1);
            end
            if (cmd.top_init)
            begin
                top_reg     <= HASH_W'(1);
                top_len_reg <= len;
                step_reg    <= len - LEN_W'(1);
            end
            if (cmd.top_step)
            begin
                top_reg  <= mod_dbl(top_reg);
                step_reg <= step_reg - LEN_W'(1);
            end
            if (cmd.vclr)
            begin
                step_reg <= '0;
            end
            if (cmd.vinc)
            begin
                step_reg <= step_reg + LEN_W'(1);
            end
            if (cmd.add)
            begin
                if (action_reg)
                begin
                    wh_reg <= mod_add(fill ? wh_reg : half_reg, term_reg);
                    rp_reg <= rp_reg + PIDX_W'(1);
                    if (count_reg < MAX_TEXT)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        tw_reg    <= mod_dbl(tw_reg);
                    end
                end
                else
                begin
                    ph_reg <= mod_add((pidx_reg == '0) ? '0 : ph_reg, term_reg);
                    lw_reg <= mod_dbl((pidx_reg == '0) ? HASH_W'(1) : lw_reg);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign ring_raddr = rp_reg - len[PIDX_W-1:0]
                        + (cmd.verify ? step_reg[PIDX_W-1:0] : PIDX_W'(0));

    rhsm_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PATTERN)
    ) u_ring (
        .clk  (clk),
        .we   (cmd.add && action_reg),
        .waddr(rp_reg),
        .wdata(sym_reg),
        .raddr(ring_raddr),
        .rdata(ring_q)
    );

    rhsm_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PATTERN)
    ) u_store (
        .clk  (clk),
        .we   (cmd.add && !action_reg),
        .waddr(pidx_reg),
        .wdata(sym_reg),
        .raddr(step_reg[PIDX_W-1:0]),
        .rdata(store_q)
    );

    assign sts.is_text   = action_reg;
    assign sts.need_top  = top_len_reg != len;
    assign sts.step_zero = step_reg == '0;
    assign sts.step_end  = step_reg == len;
    assign sts.hit       = !fill && (wh_reg == ph_reg);
    assign sts.mismatch  = ring_q != store_q;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign match          = match_reg;
    assign start_position = start_reg;
    assign window_full    = full_reg;

endmodule

/* src/rolling_hash_string_matcher_top.sv */
`timescale 1ns / 1ps
// Rabin-Karp string matcher.
// Input channel (in_valid/in_stall): one transaction per pattern symbol load
// (action 0) or text symbol (action 1). Output channel (out_valid/out_stall):
// exactly one result transaction per input transaction, in order.
// cfg_wr_en/cfg_wr_data set pattern_length; write only while idle.
// A hash hit adds an exact compare walk over the pattern and window memories.
// The first transaction after a pattern_length change first rebuilds the top
// weight 2^(m-1) by repeated doubling. Each transaction passes the four-stage
// modular multiply pipeline and the hash update behind it.
// in_stall is low only while the controller is idle; the next transaction is
// accepted while a finished result still waits in the output register.
// A stalled receiver holds the result; a second finished result waits
// inside the block until the output register frees.
// Reset: pattern length 1, hashes cleared, text position 0. Pattern and
// window memories hold no defined contents until written.
module rolling_hash_string_matcher_top import rhsm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [7:0]        symbol,
    input  logic [PIDX_W-1:0] pattern_index,
    input  logic              text_start,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              match,
    output logic [CNT_W-1:0]  start_position,
    output logic              window_full,
    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    rhsm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    rhsm_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .symbol        (symbol),
        .pattern_index (pattern_index),
        .text_start    (text_start),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .match         (match),
        .start_position(start_position),
        .window_full   (window_full)
    );

endmodule

/* src/rhsm_checker.sv */
`timescale 1ns / 1ps
`include "rolling_hash_string_matcher_top_defines.svh"

module rhsm_checker import rhsm_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              match,
    input logic [CNT_W-1:0]  start_position,
    input logic              window_full
);

    `RHSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `RHSM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `RHSM_ASSERT_NOW(a_match_full, out_valid && match, window_full)
    `RHSM_ASSERT_NOW(a_start_iff_match, out_valid, match == (start_position != '0))

endmodule

bind rolling_hash_string_matcher_top rhsm_checker u_rhsm_checker (.*);
